/* design/c8x_pkg.sv */
// Shared types and constants of the CHIP-8 instruction execute unit.
// Used by the execute logic and the top level; no dependencies.
`default_nettype none

package c8x_pkg;

	localparam int C8X_STACK_DEPTH = 16;
	localparam logic [11:0] C8X_RESET_PC = 12'h200;

	localparam logic [11:0] PC_STEP = 12'd2;
	localparam logic [11:0] PC_SKIP = 12'd4;
	localparam logic [3:0] VF_IDX = 4'hF;
	localparam logic [3:0] V0_IDX = 4'h0;

	// Major opcode groups (top nibble of the instruction word).
	localparam logic [3:0] OP_SYS     = 4'h0;
	localparam logic [3:0] OP_JP      = 4'h1;
	localparam logic [3:0] OP_CALL    = 4'h2;
	localparam logic [3:0] OP_SE_IMM  = 4'h3;
	localparam logic [3:0] OP_SNE_IMM = 4'h4;
	localparam logic [3:0] OP_SE_REG  = 4'h5;
	localparam logic [3:0] OP_LD_IMM  = 4'h6;
	localparam logic [3:0] OP_ADD_IMM = 4'h7;
	localparam logic [3:0] OP_ALU     = 4'h8;
	localparam logic [3:0] OP_SNE_REG = 4'h9;
	localparam logic [3:0] OP_LD_I    = 4'hA;
	localparam logic [3:0] OP_JP_V0   = 4'hB;
	localparam logic [3:0] OP_RND     = 4'hC;

	// System instructions within the 0NNN group.
	localparam logic [11:0] SYS_CLS = 12'h0E0;
	localparam logic [11:0] SYS_RET = 12'h0EE;

	// ALU functions of the 8XYN group (low nibble).
	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_UNKNOWN     = 3'd1,
		ST_OVERFLOW    = 3'd2,
		ST_UNDERFLOW   = 3'd3,
		ST_UNSUPPORTED = 3'd4
	} status_t;

	typedef struct packed {
		logic [15:0] opcode;
		logic [7:0]  random_byte;
	} instr_t;

	typedef struct packed {
		logic [11:0] next_pc;
		logic [11:0] index_value;
		logic        dest_write;
		logic [3:0]  dest_reg;
		logic [7:0]  dest_value;
		logic [7:0]  flag_value;
		logic        clear_screen;
		status_t     status;
	} result_t;

	// Everything one instruction does to the architectural state.
	typedef struct packed {
		logic [11:0] next_pc;
		logic [11:0] index_next;
		logic        v_we;
		logic [3:0]  v_idx;
		logic [7:0]  v_val;
		logic [7:0]  vf_next;
		logic        push;
		logic        pop;
		logic        cls;
		status_t     status;
	} exec_t;

endpackage

`default_nettype wire

/* design/c8x_chan_if.sv */
// Valid/ready channel carrying one payload beat of a selectable type.
// Depends on nothing; payload types come from c8x_pkg at the instance.
`default_nettype none

interface c8x_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/c8x_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module c8x_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* design/c8x_exec.sv */
// Decode and execute of one CHIP-8 instruction: next PC, register writes, VF, stack moves.
// Depends on c8x_pkg.
`default_nettype none

module c8x_exec
	import c8x_pkg::*;
(
	input  wire logic [15:0] op,
	input  wire logic [7:0]  rnd,
	input  wire logic [7:0]  vx,
	input  wire logic [7:0]  vy,
	input  wire logic [7:0]  vf,
	input  wire logic [11:0] pc,
	input  wire logic [11:0] index,
	input  wire logic [11:0] top,
	input  wire logic        stack_empty,
	input  wire logic        stack_full,
	output exec_t            ex
);

	logic [3:0]  x;
	logic [3:0]  y;
	logic [3:0]  n;
	logic [7:0]  nn;
	logic [11:0] nnn;
	logic [11:0] pc2;
	logic [11:0] pc4;

	logic        sets_flag;
	logic        alu_known;
	logic        flag;
	logic [8:0]  sum9;
	logic [7:0]  ax;
	logic [7:0]  ay;
	logic [7:0]  alu_val;

	assign x   = op[11:8];
	assign y   = op[7:4];
	assign n   = op[3:0];
	assign nn  = op[7:0];
	assign nnn = op[11:0];
	assign pc2 = pc + PC_STEP;
	assign pc4 = pc + PC_SKIP;
	assign sum9 = {1'b0, vx} + {1'b0, vy};

	// The flag comes from the operands as they were; VF is then written first,
	// so an operand that is VF itself sees the new flag.
	always_comb begin
		sets_flag = 1'b1;
		alu_known = 1'b1;
		flag      = 1'b0;
		case (n) inside
			ALU_MOV, ALU_OR, ALU_AND, ALU_XOR: sets_flag = 1'b0;
			ALU_ADD: flag = sum9[8];
			ALU_SUB: flag = (vx >= vy);
			ALU_SHR: flag = vx[0];
			ALU_SBN: flag = (vy >= vx);
			ALU_SHL: flag = vx[7];
			default: begin
				sets_flag = 1'b0;
				alu_known = 1'b0;
			end
		endcase

		ax = (sets_flag && (x == VF_IDX)) ? {7'd0, flag} : vx;
		ay = (sets_flag && (y == VF_IDX)) ? {7'd0, flag} : vy;

		case (n)
			ALU_MOV: alu_val = ay;
			ALU_OR:  alu_val = ax | ay;
			ALU_AND: alu_val = ax & ay;
			ALU_XOR: alu_val = ax ^ ay;
			ALU_ADD: alu_val = ax + ay;
			ALU_SUB: alu_val = ax - ay;
			ALU_SHR: alu_val = {1'b0, ax[7:1]};
			ALU_SBN: alu_val = ay - ax;
			ALU_SHL: alu_val = {ax[6:0], 1'b0};
			default: alu_val = 8'd0;
		endcase
	end

	always_comb begin
		ex            = '0;
		ex.next_pc    = pc2;
		ex.index_next = index;
		ex.v_idx      = x;
		ex.status     = ST_OK;

		unique case (op[15:12])
			OP_SYS: begin
				if (nnn == SYS_CLS) begin
					ex.cls = 1'b1;
				end else if (nnn == SYS_RET) begin
					if (stack_empty) begin
						ex.status  = ST_UNDERFLOW;
						ex.next_pc = pc;
					end else begin
						ex.pop     = 1'b1;
						ex.next_pc = top + PC_STEP;
					end
				end
			end
			OP_JP: ex.next_pc = nnn;
			OP_CALL: begin
				if (stack_full) begin
					ex.status  = ST_OVERFLOW;
					ex.next_pc = pc;
				end else begin
					ex.push    = 1'b1;
					ex.next_pc = nnn;
				end
			end
			OP_SE_IMM:  if (vx == nn) ex.next_pc = pc4;
			OP_SNE_IMM: if (vx != nn) ex.next_pc = pc4;
			OP_SE_REG:  if (vx == vy) ex.next_pc = pc4;
			OP_SNE_REG: if (vx != vy) ex.next_pc = pc4;
			OP_LD_IMM: begin
				ex.v_we  = 1'b1;
				ex.v_val = nn;
			end
			OP_ADD_IMM: begin
				ex.v_we  = 1'b1;
				ex.v_val = vx + nn;
			end
			OP_ALU: begin
				ex.v_we  = alu_known;
				ex.v_val = alu_val;
				if (!alu_known) ex.status = ST_UNKNOWN;
			end
			OP_LD_I: ex.index_next = nnn;
			// For BNNN the Y read port was pointed at V0.
			OP_JP_V0: ex.next_pc = nnn + {4'd0, vy};
			OP_RND: begin
				ex.v_we  = 1'b1;
				ex.v_val = rnd & nn;
			end
			default: ex.status = ST_UNSUPPORTED;
		endcase

		if (ex.v_we && (x == VF_IDX)) begin
			ex.vf_next = ex.v_val;
		end else if ((op[15:12] == OP_ALU) && sets_flag) begin
			ex.vf_next = {7'd0, flag};
		end else begin
			ex.vf_next = vf;
		end
	end

endmodule

`default_nettype wire

/* design/chip8_instruction_execute_unit.sv */
// Top level of the CHIP-8 instruction execute unit: input stage, register file,
// return stack and result register. Depends on c8x_pkg, c8x_chan_if, c8x_ram, c8x_exec.
`default_nettype none

// The unit executes one CHIP-8 instruction per beat on the instr channel (opcode plus a
// random byte for CXNN) and delivers one beat on the result channel with the new PC, I,
// the register write it made, VF and a status code. It sustains one instruction per clock
// cycle unless results stall; a beat goes via the input stage and result register. The
// register file V0-VE lives in two mirrored RAMs that are read when the instruction is
// taken in, with the value of the instruction ahead forwarded around them, so that
// back-to-back dependent instructions run at full rate. VF is kept in a register of its
// own. The return stack is a RAM of STACK_DEPTH entries with the top entry held in a
// register. The cfg channel loads a new PC at once; it is always ready and must only be
// used while no instruction is in flight. After reset the PC is 0x200, the registers
// are zero and the stack is empty; no clearing pass is needed.
module chip8_instruction_execute_unit
	import c8x_pkg::*;
#(
	parameter int STACK_DEPTH = C8X_STACK_DEPTH
) (
	input wire logic    clk,
	input wire logic    arst_n,
	c8x_chan_if.sink    instr,
	c8x_chan_if.source  result,
	c8x_chan_if.sink    cfg
);

	localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SDW = $clog2(STACK_DEPTH + 1);

	// Input stage.
	logic        valid_s1;
	logic [15:0] op_s1;
	logic [7:0]  rnd_s1;
	logic [3:0]  yaddr_s1;
	logic        fwd_x_s1;
	logic        fwd_y_s1;
	logic [7:0]  fwd_val_s1;

	// Architectural state.
	logic [11:0]     pc_q;
	logic [11:0]     index_q;
	logic [7:0]      vf_q;
	logic [15:0]     vvalid_q;
	logic [SDW-1:0]  depth_q;
	logic [11:0]     tos_q;
	logic            top_sel_q;

	// Result register.
	logic    out_valid_q;
	result_t res_q;

	logic        accept;
	logic        advance;
	logic [3:0]  in_x;
	logic [3:0]  in_y;
	logic [3:0]  x_s1;
	logic [7:0]  rx;
	logic [7:0]  ry;
	logic [7:0]  vx;
	logic [7:0]  vy;
	logic [11:0] stk_rdata;
	logic [11:0] top;
	logic [SDW-1:0] stk_rd_idx;
	exec_t       ex;

	// An instruction leaves the input stage when the result register is free or drains
	// in the same cycle; the input stage then refills in that same cycle.
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign instr.ready  = !valid_s1 || advance;
	assign accept       = instr.valid && instr.ready;
	assign cfg.ready    = 1'b1;

	// Read addresses are taken from the incoming beat; BNNN reads V0 on the Y port.
	assign in_x = instr.data.opcode[11:8];
	assign in_y = (instr.data.opcode[15:12] == OP_JP_V0) ? V0_IDX : instr.data.opcode[7:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// The RAM read in the accept cycle misses a write made by the instruction that
	// commits at the same edge, so that value is forwarded alongside the beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= instr.data.opcode;
			rnd_s1     <= instr.data.random_byte;
			yaddr_s1   <= in_y;
			fwd_x_s1   <= advance && ex.v_we && (ex.v_idx == in_x);
			fwd_y_s1   <= advance && ex.v_we && (ex.v_idx == in_y);
			fwd_val_s1 <= ex.v_val;
		end
	end

	c8x_ram #(
		.WIDTH (8),
		.DEPTH (16)
	) u_vx_ram (
		.clk   (clk),
		.we    (advance && ex.v_we),
		.waddr (ex.v_idx),
		.wdata (ex.v_val),
		.re    (accept),
		.raddr (in_x),
		.rdata (rx)
	);

	c8x_ram #(
		.WIDTH (8),
		.DEPTH (16)
	) u_vy_ram (
		.clk   (clk),
		.we    (advance && ex.v_we),
		.waddr (ex.v_idx),
		.wdata (ex.v_val),
		.re    (accept),
		.raddr (in_y),
		.rdata (ry)
	);

	// VF always comes from its own register; an entry never written reads as zero.
	assign x_s1 = op_s1[11:8];
	assign vx = (x_s1 == VF_IDX)     ? vf_q :
	            fwd_x_s1             ? fwd_val_s1 :
	            vvalid_q[x_s1]       ? rx : 8'd0;
	assign vy = (yaddr_s1 == VF_IDX) ? vf_q :
	            fwd_y_s1             ? fwd_val_s1 :
	            vvalid_q[yaddr_s1]   ? ry : 8'd0;

	// Return stack. The entry below the top is read every cycle, so that right after
	// a return the RAM output is the new top; tos_q takes it unless the stack moves.
	assign stk_rd_idx = depth_q - SDW'(2);

	c8x_ram #(
		.WIDTH (12),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (advance && ex.push),
		.waddr (depth_q[SAW-1:0]),
		.wdata (pc_q),
		.re    (1'b1),
		.raddr (stk_rd_idx[SAW-1:0]),
		.rdata (stk_rdata)
	);

	assign top = top_sel_q ? stk_rdata : tos_q;

	c8x_exec u_exec (
		.op          (op_s1),
		.rnd         (rnd_s1),
		.vx          (vx),
		.vy          (vy),
		.vf          (vf_q),
		.pc          (pc_q),
		.index       (index_q),
		.top         (top),
		.stack_empty (depth_q == '0),
		.stack_full  (depth_q == SDW'(STACK_DEPTH)),
		.ex          (ex)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= C8X_RESET_PC;
			index_q   <= 12'd0;
			vf_q      <= 8'd0;
			vvalid_q  <= 16'd0;
			depth_q   <= '0;
			top_sel_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				pc_q <= cfg.data;
			end else if (advance) begin
				pc_q <= ex.next_pc;
			end
			if (advance) begin
				index_q <= ex.index_next;
				vf_q    <= ex.vf_next;
				if (ex.v_we) begin
					vvalid_q[ex.v_idx] <= 1'b1;
				end
				if (ex.push) begin
					depth_q <= depth_q + SDW'(1);
				end else if (ex.pop) begin
					depth_q <= depth_q - SDW'(1);
				end
			end
			if (advance && ex.push) begin
				top_sel_q <= 1'b0;
			end else if (advance && ex.pop) begin
				top_sel_q <= 1'b1;
			end else begin
				top_sel_q <= 1'b0;
			end
		end
	end

	// Top-of-stack copy; payload only, so no reset.
	always_ff @(posedge clk) begin
		if (advance && ex.push) begin
			tos_q <= pc_q;
		end else if (!(advance && ex.pop) && top_sel_q) begin
			tos_q <= stk_rdata;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.next_pc      <= ex.next_pc;
			res_q.index_value  <= ex.index_next;
			res_q.dest_write   <= ex.v_we;
			res_q.dest_reg     <= ex.v_we ? ex.v_idx : 4'd0;
			res_q.dest_value   <= ex.v_we ? ex.v_val : 8'd0;
			res_q.flag_value   <= ex.vf_next;
			res_q.clear_screen <= ex.cls;
			res_q.status       <= ex.status;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = res_q;

endmodule

`default_nettype wire

/* tb/chip8_instruction_execute_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for chip8_instruction_execute_unit: drives instruction beats,
// predicts every result beat and compares them field by field.
// Depends on c8x_pkg, c8x_chan_if and the execute unit RTL.

module chip8_instruction_execute_unit_test
	import c8x_pkg::*;
();

	// Opcode groups that the unit rejects as unsupported, and ALU functions it does not know.
	localparam logic [3:0] OP_DRAW = 4'hD;
	localparam logic [3:0] OP_KEY = 4'hE;
	localparam logic [3:0] OP_MISC = 4'hF;
	localparam logic [3:0] ALU_UNDEF_LO = 4'h8;
	localparam logic [3:0] ALU_UNDEF_HI = 4'hF;

	logic clk;
	logic arst_n;

	c8x_chan_if #(.T(instr_t)) instr_if ();
	c8x_chan_if #(.T(result_t)) result_if ();
	c8x_chan_if #(.T(logic [11:0])) cfg_if ();

	chip8_instruction_execute_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.instr(instr_if),
		.result(result_if),
		.cfg(cfg_if)
	);

	// Architectural state as the testbench expects it to be after the last accepted beat.
	logic [7:0] v_regs [16];
	logic [11:0] index_q;
	logic [11:0] pc_q;
	logic [11:0] call_stack [C8X_STACK_DEPTH];
	int call_depth;

	result_t pending_results [$];
	int mismatch_count;

	// When set, neither side idles: no gaps on the instruction channel and no stalls on
	// the result channel.
	bit steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Executes one instruction against the expected state and returns the result beat it
	// should produce. Flag-setting ALU functions write VF first and then read their
	// operands again, so an operand VF already holds the new flag.
	function automatic result_t execute_instr(input logic [15:0] op, input logic [7:0] rnd);
		logic [3:0] x;
		logic [3:0] y;
		logic [3:0] fn;
		logic [7:0] nn;
		logic [11:0] nnn;
		logic [7:0] vx;
		logic [7:0] vy;
		logic [7:0] val;
		logic [7:0] flag;
		logic [8:0] sum;
		logic [11:0] next;
		logic wr;
		logic sets_flag;
		result_t res;
		x = op[11:8];
		y = op[7:4];
		fn = op[3:0];
		nn = op[7:0];
		nnn = op[11:0];
		vx = v_regs[x];
		vy = v_regs[y];
		next = pc_q + PC_STEP;
		res = '0;
		res.status = ST_OK;
		wr = 1'b0;
		val = '0;
		flag = '0;
		sets_flag = 1'b0;
		case (op[15:12])
		OP_SYS: begin
			if (nnn == SYS_CLS) begin
				res.clear_screen = 1'b1;
			end else if (nnn == SYS_RET) begin
				if (call_depth == 0) begin
					res.status = ST_UNDERFLOW;
					next = pc_q;
				end else begin
					call_depth--;
					next = call_stack[call_depth] + PC_STEP;
				end
			end
		end
		OP_JP: next = nnn;
		OP_CALL: begin
			if (call_depth >= C8X_STACK_DEPTH) begin
				res.status = ST_OVERFLOW;
				next = pc_q;
			end else begin
				call_stack[call_depth] = pc_q;
				call_depth++;
				next = nnn;
			end
		end
		OP_SE_IMM: if (vx == nn) next = pc_q + PC_SKIP;
		OP_SNE_IMM: if (vx != nn) next = pc_q + PC_SKIP;
		OP_SE_REG: if (vx == vy) next = pc_q + PC_SKIP;
		OP_SNE_REG: if (vx != vy) next = pc_q + PC_SKIP;
		OP_LD_IMM: begin
			wr = 1'b1;
			val = nn;
		end
		OP_ADD_IMM: begin
			wr = 1'b1;
			val = vx + nn;
		end
		OP_ALU: begin
			wr = 1'b1;
			case (fn) inside
			ALU_MOV, ALU_OR, ALU_AND, ALU_XOR: ;
			ALU_ADD: begin
				sum = {1'b0, vx} + {1'b0, vy};
				flag = {7'b0, sum[8]};
				sets_flag = 1'b1;
			end
			ALU_SUB: begin
				flag = (vx >= vy) ? 8'd1 : 8'd0;
				sets_flag = 1'b1;
			end
			ALU_SHR: begin
				flag = {7'b0, vx[0]};
				sets_flag = 1'b1;
			end
			ALU_SBN: begin
				flag = (vy >= vx) ? 8'd1 : 8'd0;
				sets_flag = 1'b1;
			end
			ALU_SHL: begin
				flag = {7'b0, vx[7]};
				sets_flag = 1'b1;
			end
			default: begin
				wr = 1'b0;
				res.status = ST_UNKNOWN;
			end
			endcase
			if (sets_flag) begin
				v_regs[VF_IDX] = flag;
				vx = v_regs[x];
				vy = v_regs[y];
			end
			case (fn)
			ALU_MOV: val = vy;
			ALU_OR: val = vx | vy;
			ALU_AND: val = vx & vy;
			ALU_XOR: val = vx ^ vy;
			ALU_ADD: val = vx + vy;
			ALU_SUB: val = vx - vy;
			ALU_SHR: val = vx >> 1;
			ALU_SBN: val = vy - vx;
			ALU_SHL: val = vx << 1;
			default: ;
			endcase
		end
		OP_LD_I: index_q = nnn;
		OP_JP_V0: next = nnn + {4'b0, v_regs[V0_IDX]};
		OP_RND: begin
			wr = 1'b1;
			val = rnd & nn;
		end
		default: res.status = ST_UNSUPPORTED;
		endcase
		if (wr) v_regs[x] = val;
		pc_q = next;
		res.next_pc = pc_q;
		res.index_value = index_q;
		res.dest_write = wr;
		res.dest_reg = wr ? x : 4'h0;
		res.dest_value = wr ? val : 8'h00;
		res.flag_value = v_regs[VF_IDX];
		return res;
	endfunction

	// ALU, load, add and random instructions. With narrow set the registers come from
	// V0-V2 and VF, so that neighboring instructions depend on each other.
	function automatic logic [15:0] random_data_opcode(input bit narrow);
		logic [3:0] x;
		logic [3:0] y;
		logic [3:0] fn;
		logic [7:0] nn;
		int pick;
		x = 4'($urandom);
		y = 4'($urandom);
		nn = 8'($urandom);
		fn = 4'($urandom_range(7));
		pick = $urandom_range(99);
		if (narrow) begin
			x = (x[1:0] == 2'd3) ? VF_IDX : {2'b0, x[1:0]};
			y = (y[1:0] == 2'd3) ? VF_IDX : {2'b0, y[1:0]};
		end
		if ($urandom_range(7) == 0) begin
			fn = ALU_SHL;
		end else if ($urandom_range(15) == 0) begin
			fn = 4'($urandom_range(ALU_UNDEF_LO, ALU_UNDEF_HI));
		end
		if (pick < 15) return {OP_LD_IMM, x, nn};
		if (pick < 30) return {OP_ADD_IMM, x, nn};
		if (pick < 38) return {OP_RND, x, nn};
		return {OP_ALU, x, y, fn};
	endfunction

	// Any instruction, weighted toward the ones that do something. Half of the immediate
	// skips compare against the register's current value so that both outcomes occur.
	function automatic logic [15:0] random_opcode();
		logic [3:0] x;
		logic [3:0] y;
		logic [7:0] nn;
		logic [11:0] nnn;
		int pick;
		x = 4'($urandom);
		y = 4'($urandom);
		nn = 8'($urandom);
		nnn = 12'($urandom);
		pick = $urandom_range(99);
		if (nn[7]) y = x;
		if (nn[6]) nn = v_regs[x];
		if (pick < 2) return {OP_SYS, SYS_CLS};
		if (pick < 5) return {OP_SYS, SYS_RET};
		if (pick < 7) return {OP_SYS, nnn};
		if (pick < 11) return {OP_JP, nnn};
		if (pick < 16) return {OP_CALL, nnn};
		if (pick < 22) return {OP_SE_IMM, x, nn};
		if (pick < 28) return {OP_SNE_IMM, x, nn};
		if (pick < 33) return {OP_SE_REG, x, y, nnn[3:0]};
		if (pick < 38) return {OP_SNE_REG, x, y, nnn[3:0]};
		if (pick < 43) return {OP_LD_I, nnn};
		if (pick < 47) return {OP_JP_V0, nnn};
		if (pick < 49) return {OP_DRAW, nnn};
		if (pick < 51) return {OP_KEY, nnn};
		if (pick < 53) return {OP_MISC, nnn};
		return random_data_opcode(1'b0);
	endfunction

	// Presents one instruction beat and waits for it to be taken. The task is entered right
	// after an edge at which the previous beat was accepted, so valid stays high into the
	// next beat unless a random gap lowers it first.
	task automatic send_instr(input logic [15:0] op);
		logic [7:0] rnd;
		rnd = 8'($urandom);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 25) begin
			instr_if.valid = 1'b0;
			@(negedge clk);
		end
		instr_if.valid = 1'b1;
		instr_if.data = '{opcode: op, random_byte: rnd};
		do @(posedge clk); while (!instr_if.ready);
		pending_results.push_back(execute_instr(op, rnd));
	endtask

	// Ends the current stream of beats and waits until every expected result is in.
	task automatic drain_results();
		@(negedge clk);
		instr_if.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Loads a new start address; the unit moves its PC there at once.
	task automatic write_start_address(input logic [11:0] addr);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.data = addr;
		do @(posedge clk); while (!cfg_if.ready);
		pc_q = addr;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// Every instruction group at least once, the ALU carry and borrow edges, VF as
	// destination and as operand, unknown ALU functions, ignored system calls, stack
	// underflow, a skip that wraps the PC, and the unsupported groups.
	task automatic test_directed();
		logic [15:0] ops [30];
		ops = '{
			{OP_SYS, SYS_RET},
			{OP_SYS, SYS_CLS},
			{OP_SYS, 12'hFFF},
			{OP_LD_IMM, 4'h0, 8'hFF},
			{OP_LD_IMM, 4'h1, 8'h01},
			{OP_ALU, 4'h0, 4'h1, ALU_ADD},
			{OP_ALU, 4'h0, 4'h1, ALU_SUB},
			{OP_ALU, 4'h0, 4'h1, ALU_SBN},
			{OP_ALU, 4'h0, 4'h1, ALU_SHR},
			{OP_ALU, 4'h1, 4'h0, ALU_SHL},
			{OP_LD_IMM, 4'hF, 8'h80},
			{OP_ALU, 4'hF, 4'h0, ALU_SHL},
			{OP_ALU, 4'h2, 4'hF, ALU_ADD},
			{OP_ALU, 4'h2, 4'h0, ALU_MOV},
			{OP_ALU, 4'h2, 4'h1, ALU_OR},
			{OP_ALU, 4'h2, 4'h0, ALU_AND},
			{OP_ALU, 4'h2, 4'h1, ALU_XOR},
			{OP_ALU, 4'h2, 4'h0, ALU_UNDEF_LO},
			{OP_ALU, 4'h2, 4'h0, ALU_UNDEF_HI},
			{OP_ADD_IMM, 4'h0, 8'hFF},
			{OP_SNE_IMM, 4'hE, 8'h00},
			{OP_SE_REG, 4'hE, 4'hD, 4'hF},
			{OP_SNE_REG, 4'hE, 4'h0, 4'h5},
			{OP_LD_I, 12'hFFF},
			{OP_JP_V0, 12'hFFF},
			{OP_RND, 4'h3, 8'hFF},
			{OP_CALL, 12'hFFE},
			{OP_SE_IMM, 4'hE, 8'h00},
			{OP_SYS, SYS_RET},
			{OP_DRAW, 12'h123}
		};
		foreach (ops[k]) send_instr(ops[k]);
		send_instr({OP_KEY, 12'hFFF});
		send_instr({OP_MISC, 12'h000});
		send_instr({OP_JP, 12'h000});
	endtask

	task automatic test_random_mix(input int count);
		repeat (count) send_instr(random_opcode());
	endtask

	// Rounds of 12 to 20 nested calls, enough at times to overflow the return stack, then
	// 12 to 20 returns that may underflow it, with ordinary instructions between them.
	task automatic test_call_nesting(input int rounds);
		logic [11:0] target;
		int depth;
		repeat (rounds) begin
			depth = $urandom_range(12, 20);
			repeat (depth) begin
				target = 12'($urandom);
				send_instr({OP_CALL, target});
				repeat ($urandom_range(2)) send_instr(random_data_opcode(1'b0));
			end
			depth = $urandom_range(12, 20);
			repeat (depth) begin
				send_instr({OP_SYS, SYS_RET});
				repeat ($urandom_range(2)) send_instr(random_data_opcode(1'b0));
			end
		end
	endtask

	// Back-to-back dependent ALU work on a few registers at full rate in both directions.
	task automatic test_alu_chains(input int count);
		steady = 1'b1;
		repeat (count) send_instr(random_data_opcode(1'b1));
		steady = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [11:0] want, input logic [11:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// The result side stalls at random on a quarter of the cycles unless a steady stretch runs.
	always @(negedge clk) begin
		result_if.ready = steady || ($urandom_range(99) >= 25);
	end

	// Each accepted result beat is matched against the oldest outstanding expectation.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no instruction outstanding");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("next_pc", want.next_pc, result_if.data.next_pc);
				check_field("index_value", want.index_value, result_if.data.index_value);
				check_field("dest_write", 12'(want.dest_write),
					12'(result_if.data.dest_write));
				check_field("dest_reg", 12'(want.dest_reg), 12'(result_if.data.dest_reg));
				check_field("dest_value", 12'(want.dest_value),
					12'(result_if.data.dest_value));
				check_field("flag_value", 12'(want.flag_value),
					12'(result_if.data.flag_value));
				check_field("clear_screen", 12'(want.clear_screen),
					12'(result_if.data.clear_screen));
				check_field("status", 12'(want.status), 12'(result_if.data.status));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		steady = 1'b0;
		mismatch_count = 0;
		instr_if.valid = 1'b0;
		instr_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		result_if.ready = 1'b0;
		foreach (v_regs[k]) v_regs[k] = '0;
		foreach (call_stack[k]) call_stack[k] = '0;
		index_q = '0;
		pc_q = C8X_RESET_PC;
		call_depth = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// The reset start address is used first; every later phase begins from a new one,
		// written only once the unit has delivered everything outstanding.
		test_directed();
		drain_results();
		write_start_address(12'hFFE);
		test_random_mix(100);
		drain_results();
		write_start_address(12'h000);
		test_call_nesting(2);
		drain_results();
		write_start_address(12'hFFF);
		test_alu_chains(100);
		drain_results();
		write_start_address(12'($urandom));
		test_random_mix(70);
		drain_results();

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// A hung handshake ends the run here.
	initial begin
		#1000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
